/* sv/ddo_pkg.sv */
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and the arctangent table for the odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  localparam logic signed [33:0] PI_Q      = 34'sd843314857;
  localparam logic signed [33:0] TWO_PI_Q  = 34'sd1686629714;
  localparam logic signed [33:0] HALF_PI_Q = 34'sd421657428;
  localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;
  localparam logic [55:0]        CAP_POS   = 56'h7F_FFFF_FFFF;
  localparam logic [55:0]        CAP_ANG   = 56'h7FFF_FFFF;

  localparam logic [1:0] REG_DIST_PER_TICK = 2'd0;
  localparam logic [1:0] REG_INV_TRACK     = 2'd1;
  localparam logic [1:0] REG_RATE          = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RESYNC, S_MLOAD, S_MLO, S_MHI, S_MACC, S_MFIN,
    S_MID, S_WRAP_MID, S_FOLD, S_ROT, S_POSE, S_WRAP_TH, S_THSTORE, S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_CAPTURE, DP_MLOAD, DP_MLO, DP_MHI, DP_MACC, DP_MFIN, DP_MID,
    DP_WRAP, DP_FOLD, DP_ROT, DP_POSE, DP_THSTORE, DP_RESYNC, DP_OUT
  } dp_cmd_t;

  typedef enum logic [2:0] {
    MOP_DR, MOP_DL, MOP_DTH, MOP_DX, MOP_DY, MOP_VX, MOP_VY, MOP_OM
  } mop_t;

  typedef struct packed {
    dp_cmd_t    cmd;
    mop_t       op;
    logic [4:0] iter;
  } ctl_cmd_t;

  typedef struct packed {
    logic act;
    logic wrap_out;
  } ctl_sts_t;

  typedef struct packed {
    logic [31:0] dist_per_tick;
    logic [31:0] inv_track;
    logic [15:0] rate;
  } cfg_t;

  function automatic logic [31:0] atan_val(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd210828714;
      5'd1:  v = 32'd124459457;
      5'd2:  v = 32'd65760959;
      5'd3:  v = 32'd33381290;
      5'd4:  v = 32'd16755422;
      5'd5:  v = 32'd8385879;
      5'd6:  v = 32'd4193963;
      5'd7:  v = 32'd2097109;
      5'd8:  v = 32'd1048571;
      5'd9:  v = 32'd524287;
      5'd10: v = 32'd262144;
      5'd11: v = 32'd131072;
      5'd12: v = 32'd65536;
      5'd13: v = 32'd32768;
      5'd14: v = 32'd16384;
      5'd15: v = 32'd8192;
      5'd16: v = 32'd4096;
      5'd17: v = 32'd2048;
      5'd18: v = 32'd1024;
      5'd19: v = 32'd512;
      5'd20: v = 32'd256;
      5'd21: v = 32'd128;
      5'd22: v = 32'd64;
      5'd23: v = 32'd32;
      5'd24: v = 32'd16;
      5'd25: v = 32'd8;
      5'd26: v = 32'd4;
      5'd27: v = 32'd2;
      5'd28: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* sv/differential_drive_odometry.sv */
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Wheel encoder odometry with midpoint heading integration.
//
// Requests arrive on in_valid/in_ready with action, right_count, left_count;
// one result per request leaves on out_valid/out_ready with pose and speed.
// Registers are written on cfg_valid/cfg_ready (always ready) by cfg_index.
// Resync request: dispatch, resync and finish states, then a registered result.
// Update request: eight passes through one shared 32x32 multiplier, each
// through load, low, high, accumulate and finish states, one cordic step
// per cycle and up to three wrap steps lead to the result.
// in_ready returns high together with out_valid, so the block takes no new
// request until the previous one has reached its result.
// The result sits in an output register; a stalled receiver holds the block
// in its final state until the previous result is taken.
// Reset clears pose, stored counts and registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 action,
  input  wire signed [31:0]   right_count,
  input  wire signed [31:0]   left_count,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic signed [39:0]  pos_x,
  output logic signed [39:0]  pos_y,
  output logic signed [30:0]  heading,
  output logic signed [39:0]  vel_x,
  output logic signed [39:0]  vel_y,
  output logic signed [31:0]  omega,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_index,
  input  wire  [31:0]         cfg_data
);

  ddo_pkg::cfg_t     cfg;
  ddo_pkg::ctl_cmd_t cmd;
  ddo_pkg::ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dist_per_tick <= 32'd16777216;
      cfg.inv_track     <= 32'd42949673;
      cfg.rate          <= 16'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ddo_pkg::REG_DIST_PER_TICK: cfg.dist_per_tick <= cfg_data;
        ddo_pkg::REG_INV_TRACK:     cfg.inv_track     <= cfg_data;
        ddo_pkg::REG_RATE:          cfg.rate          <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ddo_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ddo_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg         (cfg),
    .action      (action),
    .right_count (right_count),
    .left_count  (left_count),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading),
    .vel_x       (vel_x),
    .vel_y       (vel_y),
    .omega       (omega)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block took a second request while busy");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (34'(heading) <= ddo_pkg::PI_Q) && (34'(heading) >= -ddo_pkg::PI_Q))
    else $error("heading outside plus or minus pi");
`endif

endmodule

`default_nettype wire

/* sv/ddo_ctrl.sv */
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer: steps the datapath through multiplies, cordic and wrapping.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_ctrl #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  ddo_pkg::ctl_sts_t   sts,
  output ddo_pkg::ctl_cmd_t   cmd
);

  localparam int NSTEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int IW     = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
  localparam logic [IW-1:0] ITER_LAST = IW'(NSTEPS - 1);

  ddo_pkg::state_t state, state_next;
  ddo_pkg::mop_t   op, op_next;
  logic [IW-1:0]   iter, iter_next;
  logic            out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ddo_pkg::S_IDLE;
      op        <= ddo_pkg::MOP_DR;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      iter  <= iter_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    op_next    = op;
    iter_next  = iter;
    unique case (state)
      ddo_pkg::S_IDLE: begin
        if (in_valid) state_next = ddo_pkg::S_DISPATCH;
      end
      ddo_pkg::S_DISPATCH: begin
        if (sts.act) begin
          state_next = ddo_pkg::S_RESYNC;
        end else begin
          state_next = ddo_pkg::S_MLOAD;
          op_next    = ddo_pkg::MOP_DR;
        end
      end
      ddo_pkg::S_RESYNC: state_next = ddo_pkg::S_FINISH;
      ddo_pkg::S_MLOAD:  state_next = ddo_pkg::S_MLO;
      ddo_pkg::S_MLO:    state_next = ddo_pkg::S_MHI;
      ddo_pkg::S_MHI:    state_next = ddo_pkg::S_MACC;
      ddo_pkg::S_MACC:   state_next = ddo_pkg::S_MFIN;
      ddo_pkg::S_MFIN: begin
        unique case (op)
          ddo_pkg::MOP_DR: begin
            state_next = ddo_pkg::S_MLOAD;
            op_next    = ddo_pkg::MOP_DL;
          end
          ddo_pkg::MOP_DL: begin
            state_next = ddo_pkg::S_MLOAD;
            op_next    = ddo_pkg::MOP_DTH;
          end
          ddo_pkg::MOP_DTH: state_next = ddo_pkg::S_MID;
          ddo_pkg::MOP_DX: begin
            state_next = ddo_pkg::S_MLOAD;
            op_next    = ddo_pkg::MOP_DY;
          end
          ddo_pkg::MOP_DY: state_next = ddo_pkg::S_POSE;
          ddo_pkg::MOP_VX: begin
            state_next = ddo_pkg::S_MLOAD;
            op_next    = ddo_pkg::MOP_VY;
          end
          ddo_pkg::MOP_VY: begin
            state_next = ddo_pkg::S_MLOAD;
            op_next    = ddo_pkg::MOP_OM;
          end
          ddo_pkg::MOP_OM: state_next = ddo_pkg::S_FINISH;
          default:         state_next = ddo_pkg::S_FINISH;
        endcase
      end
      ddo_pkg::S_MID: state_next = ddo_pkg::S_WRAP_MID;
      ddo_pkg::S_WRAP_MID: begin
        if (!sts.wrap_out) state_next = ddo_pkg::S_FOLD;
      end
      ddo_pkg::S_FOLD: begin
        state_next = ddo_pkg::S_ROT;
        iter_next  = '0;
      end
      ddo_pkg::S_ROT: begin
        if (iter == ITER_LAST) begin
          state_next = ddo_pkg::S_MLOAD;
          op_next    = ddo_pkg::MOP_DX;
          iter_next  = '0;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      ddo_pkg::S_POSE: state_next = ddo_pkg::S_WRAP_TH;
      ddo_pkg::S_WRAP_TH: begin
        if (!sts.wrap_out) state_next = ddo_pkg::S_THSTORE;
      end
      ddo_pkg::S_THSTORE: begin
        state_next = ddo_pkg::S_MLOAD;
        op_next    = ddo_pkg::MOP_VX;
      end
      ddo_pkg::S_FINISH: begin
        if (!out_valid || out_ready) state_next = ddo_pkg::S_IDLE;
      end
      default: state_next = ddo_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.cmd  = ddo_pkg::DP_NOP;
    cmd.op   = op;
    cmd.iter = 5'(iter);
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ddo_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.cmd = ddo_pkg::DP_CAPTURE;
      end
      ddo_pkg::S_DISPATCH: cmd.cmd = ddo_pkg::DP_NOP;
      ddo_pkg::S_RESYNC:   cmd.cmd = ddo_pkg::DP_RESYNC;
      ddo_pkg::S_MLOAD:    cmd.cmd = ddo_pkg::DP_MLOAD;
      ddo_pkg::S_MLO:      cmd.cmd = ddo_pkg::DP_MLO;
      ddo_pkg::S_MHI:      cmd.cmd = ddo_pkg::DP_MHI;
      ddo_pkg::S_MACC:     cmd.cmd = ddo_pkg::DP_MACC;
      ddo_pkg::S_MFIN:     cmd.cmd = ddo_pkg::DP_MFIN;
      ddo_pkg::S_MID:      cmd.cmd = ddo_pkg::DP_MID;
      ddo_pkg::S_WRAP_MID: cmd.cmd = ddo_pkg::DP_WRAP;
      ddo_pkg::S_FOLD:     cmd.cmd = ddo_pkg::DP_FOLD;
      ddo_pkg::S_ROT:      cmd.cmd = ddo_pkg::DP_ROT;
      ddo_pkg::S_POSE:     cmd.cmd = ddo_pkg::DP_POSE;
      ddo_pkg::S_WRAP_TH:  cmd.cmd = ddo_pkg::DP_WRAP;
      ddo_pkg::S_THSTORE:  cmd.cmd = ddo_pkg::DP_THSTORE;
      ddo_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.cmd  = ddo_pkg::DP_OUT;
          out_load = 1'b1;
        end
      end
      default: cmd.cmd = ddo_pkg::DP_NOP;
    endcase
  end

endmodule

`default_nettype wire

/* sv/ddo_datapath.sv */
// ----------------------------------------------------------------------------
// ddo_datapath
// Pose state, shared 32x32 multiplier, cordic rotator and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_datapath (
  input  wire                       clk,
  input  wire                       rst,
  input  ddo_pkg::ctl_cmd_t         cmd,
  output ddo_pkg::ctl_sts_t         sts,
  input  ddo_pkg::cfg_t             cfg,
  input  wire                       action,
  input  wire signed [31:0]         right_count,
  input  wire signed [31:0]         left_count,
  output logic signed [39:0]        pos_x,
  output logic signed [39:0]        pos_y,
  output logic signed [30:0]        heading,
  output logic signed [39:0]        vel_x,
  output logic signed [39:0]        vel_y,
  output logic signed [31:0]        omega
);

  logic [31:0]        last_r, last_l;
  logic               act;
  logic signed [31:0] dtr, dtl;
  logic signed [56:0] dr, dl, dd;
  logic signed [31:0] dth, om, theta;
  logic signed [39:0] dx, dy, vx, vy, xp, yp;
  logic signed [33:0] z, cx, cy;
  logic               flip;

  logic [55:0] ma;
  logic [31:0] mb;
  logic        mneg;
  logic [63:0] prod;
  logic [88:0] acc;

  logic signed [57:0] a_src, a_abs, res;
  logic [31:0]        b_src;
  logic               b_neg;
  logic signed [33:0] c_abs, s_abs;
  logic [88:0]        rnd_sum, shifted;
  logic [55:0]        rmag;
  logic signed [57:0] sum_dd, abs_dd;
  logic [56:0]        half_dd;
  logic [31:0]        abs_dth;
  logic [32:0]        half_dth;
  logic signed [33:0] xs, ys;
  logic signed [33:0] atan_z;

  assign sts.act      = act;
  assign sts.wrap_out = (z > ddo_pkg::PI_Q) || (z < -ddo_pkg::PI_Q);

  // multiplier operand selection
  always_comb begin
    c_abs = cx[33] ? -cx : cx;
    s_abs = cy[33] ? -cy : cy;
    a_src = '0;
    b_src = '0;
    b_neg = 1'b0;
    unique case (cmd.op)
      ddo_pkg::MOP_DR:  begin a_src = 58'(dtr); b_src = cfg.dist_per_tick; end
      ddo_pkg::MOP_DL:  begin a_src = 58'(dtl); b_src = cfg.dist_per_tick; end
      ddo_pkg::MOP_DTH: begin a_src = 58'(dr) - 58'(dl); b_src = cfg.inv_track; end
      ddo_pkg::MOP_DX: begin
        a_src = 58'(dd);
        b_src = c_abs[31:0];
        b_neg = flip ? (cx > 34'sd0) : cx[33];
      end
      ddo_pkg::MOP_DY: begin
        a_src = 58'(dd);
        b_src = s_abs[31:0];
        b_neg = flip ? (cy > 34'sd0) : cy[33];
      end
      ddo_pkg::MOP_VX:  begin a_src = 58'(dx); b_src = 32'(cfg.rate); end
      ddo_pkg::MOP_VY:  begin a_src = 58'(dy); b_src = 32'(cfg.rate); end
      ddo_pkg::MOP_OM:  begin a_src = 58'(dth); b_src = 32'(cfg.rate); end
      default:          begin a_src = '0; b_src = '0; end
    endcase
    a_abs = a_src[57] ? -a_src : a_src;
  end

  // round, shift and saturate
  always_comb begin
    rnd_sum = acc;
    shifted = acc;
    rmag    = acc[55:0];
    unique case (cmd.op)
      ddo_pkg::MOP_DR, ddo_pkg::MOP_DL: begin
        rnd_sum = acc + 89'(128);
        shifted = rnd_sum >> 8;
        rmag    = shifted[55:0];
      end
      ddo_pkg::MOP_DTH: begin
        rnd_sum = acc + 89'(524288);
        shifted = rnd_sum >> 20;
        rmag    = (shifted > 89'(ddo_pkg::CAP_ANG)) ? ddo_pkg::CAP_ANG : shifted[55:0];
      end
      ddo_pkg::MOP_DX, ddo_pkg::MOP_DY: begin
        rnd_sum = acc + 89'(536870912);
        shifted = rnd_sum >> 30;
        rmag    = (shifted > 89'(ddo_pkg::CAP_POS)) ? ddo_pkg::CAP_POS : shifted[55:0];
      end
      ddo_pkg::MOP_VX, ddo_pkg::MOP_VY: begin
        rmag = (acc > 89'(ddo_pkg::CAP_POS)) ? ddo_pkg::CAP_POS : acc[55:0];
      end
      ddo_pkg::MOP_OM: begin
        rmag = (acc > 89'(ddo_pkg::CAP_ANG)) ? ddo_pkg::CAP_ANG : acc[55:0];
      end
      default: rmag = acc[55:0];
    endcase
    res = mneg ? -58'(rmag) : 58'(rmag);
  end

  // distance, half heading change and cordic shift terms
  always_comb begin
    sum_dd   = 58'(dr) + 58'(dl);
    abs_dd   = sum_dd[57] ? -sum_dd : sum_dd;
    half_dd  = 57'((abs_dd[56:0] + 57'd1) >> 1);
    abs_dth  = dth[31] ? 32'(-dth) : 32'(dth);
    half_dth = (33'(abs_dth) + 33'd1) >> 1;
    xs       = cx >>> cmd.iter;
    ys       = cy >>> cmd.iter;
    atan_z   = 34'(ddo_pkg::atan_val(cmd.iter));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_r <= '0;
      last_l <= '0;
      xp     <= '0;
      yp     <= '0;
      theta  <= '0;
    end else begin
      unique case (cmd.cmd)
        ddo_pkg::DP_CAPTURE: begin
          last_r <= right_count;
          last_l <= left_count;
        end
        ddo_pkg::DP_POSE: begin
          xp <= xp + dx;
          yp <= yp + dy;
        end
        ddo_pkg::DP_THSTORE: theta <= z[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.cmd)
      ddo_pkg::DP_CAPTURE: begin
        dtr <= right_count - last_r;
        dtl <= left_count - last_l;
        act <= action;
      end
      ddo_pkg::DP_MLOAD: begin
        ma   <= a_abs[55:0];
        mb   <= b_src;
        mneg <= a_src[57] ^ b_neg;
      end
      ddo_pkg::DP_MLO: prod <= 64'(ma[31:0]) * 64'(mb);
      ddo_pkg::DP_MHI: begin
        acc  <= 89'(prod);
        prod <= 64'(ma[55:32]) * 64'(mb);
      end
      ddo_pkg::DP_MACC: acc <= acc + 89'({prod, 32'd0});
      ddo_pkg::DP_MFIN: begin
        unique case (cmd.op)
          ddo_pkg::MOP_DR:  dr  <= res[56:0];
          ddo_pkg::MOP_DL:  dl  <= res[56:0];
          ddo_pkg::MOP_DTH: dth <= res[31:0];
          ddo_pkg::MOP_DX:  dx  <= res[39:0];
          ddo_pkg::MOP_DY:  dy  <= res[39:0];
          ddo_pkg::MOP_VX:  vx  <= res[39:0];
          ddo_pkg::MOP_VY:  vy  <= res[39:0];
          ddo_pkg::MOP_OM:  om  <= res[31:0];
          default: ;
        endcase
      end
      ddo_pkg::DP_MID: begin
        dd <= sum_dd[57] ? -57'(half_dd) : 57'(half_dd);
        z  <= dth[31] ? 34'(theta) - 34'(half_dth) : 34'(theta) + 34'(half_dth);
      end
      ddo_pkg::DP_WRAP: begin
        if (z > ddo_pkg::PI_Q) begin
          z <= z - ddo_pkg::TWO_PI_Q;
        end else if (z < -ddo_pkg::PI_Q) begin
          z <= z + ddo_pkg::TWO_PI_Q;
        end
      end
      ddo_pkg::DP_FOLD: begin
        cx <= ddo_pkg::GAIN_Q30;
        cy <= '0;
        if (z > ddo_pkg::HALF_PI_Q) begin
          z    <= z - ddo_pkg::PI_Q;
          flip <= 1'b1;
        end else if (z < -ddo_pkg::HALF_PI_Q) begin
          z    <= z + ddo_pkg::PI_Q;
          flip <= 1'b1;
        end else begin
          flip <= 1'b0;
        end
      end
      ddo_pkg::DP_ROT: begin
        if (!z[33]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          z  <= z - atan_z;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          z  <= z + atan_z;
        end
      end
      ddo_pkg::DP_POSE: z <= 34'(theta) + 34'(dth);
      ddo_pkg::DP_RESYNC: begin
        vx <= '0;
        vy <= '0;
        om <= '0;
      end
      ddo_pkg::DP_OUT: begin
        pos_x   <= xp;
        pos_y   <= yp;
        heading <= theta[30:0];
        vel_x   <= vx;
        vel_y   <= vy;
        omega   <= om;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
